### rtl/core/icdg_pkg.sv
// Shared constants, codes and types of the central-difference image gradient.
package icdg_pkg;

    // Size limits and field widths.
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int PIXEL_BITS = 16;
    localparam int SLOPE_BITS = PIXEL_BITS + 2;
    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
    localparam int WIDTH_BITS = COL_BITS + 1;
    localparam int HEIGHT_BITS = ROW_BITS + 1;
    localparam int CFG_DATA_BITS = HEIGHT_BITS;

    // Configuration register indexes.
    typedef logic [1:0] t_cfg_index;
    localparam t_cfg_index CFG_AXIS_MODE    = 2'd0;
    localparam t_cfg_index CFG_IMAGE_WIDTH  = 2'd1;
    localparam t_cfg_index CFG_IMAGE_HEIGHT = 2'd2;

    // Axis selection codes.
    localparam logic AXIS_X = 1'b0;
    localparam logic AXIS_Y = 1'b1;

    // Reset values of the size registers.
    localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = WIDTH_BITS'(MAX_WIDTH);
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = HEIGHT_BITS'(MAX_HEIGHT);

    typedef logic signed [PIXEL_BITS-1:0] t_pixel;
    typedef logic signed [SLOPE_BITS-1:0] t_slope;
    typedef logic [COL_BITS-1:0]          t_col;
    typedef logic [ROW_BITS-1:0]          t_row;

    // Work stage contents for one accepted pixel.
    typedef struct packed {
        t_pixel pix;
        t_pixel pix_before;
        t_pixel pix_two_before;
        logic   mode;
        t_col   col;
        t_row   row;
        logic   last_col;
        logic   last_row;
    } t_stage;

endpackage

### rtl/core/image_central_difference_gradient.sv
// Top level of the central-difference image gradient over a raster pixel stream.
//
//  Channel  | Direction | Handshake                         | Payload
//  ---------+-----------+-----------------------------------+-------------------------------
//  pixel    | in        | i_pixel_valid / o_pixel_ready     | i_pixel
//  result   | out       | o_result_valid / i_result_ready   | o_slope, o_out_row,
//           |           |                                   | o_out_column, o_frame_last
//  config   | in        | i_cfg_valid / o_cfg_ready         | i_cfg_index, i_cfg_data
//
// One pixel beat is taken per cycle unless a stalled output stops the work stage
// and input. A pixel reads both line buffers at its column when accepted, its
// results are formed in the work stage in the next cycle and leave through the
// output register. At a line end (x mode) or on the last row (y mode) a pixel gives
// two results and holds the input until the second is loaded. Reset, synchronous and
// active low, clears counters, valid flags, settings and history, not line buffers.
module image_central_difference_gradient (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_pixel_valid,
    output logic                                o_pixel_ready,
    input  icdg_pkg::t_pixel                    i_pixel,
    output logic                                o_result_valid,
    input  logic                                i_result_ready,
    output icdg_pkg::t_slope                    o_slope,
    output icdg_pkg::t_row                      o_out_row,
    output icdg_pkg::t_col                      o_out_column,
    output logic                                o_frame_last,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  icdg_pkg::t_cfg_index                i_cfg_index,
    input  logic [icdg_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    // Configuration registers.
    logic                                r_axis_mode;
    logic [icdg_pkg::WIDTH_BITS-1:0]     r_image_width;
    logic [icdg_pkg::HEIGHT_BITS-1:0]    r_image_height;

    // Raster position and pixel history.
    icdg_pkg::t_col   r_col_count, n_col_count;
    icdg_pkg::t_row   r_row_count, n_row_count;
    icdg_pkg::t_pixel r_pix_before;
    icdg_pkg::t_pixel r_pix_two_before;

    // Line buffers and their registered read data.
    icdg_pkg::t_pixel r_mem_older [icdg_pkg::MAX_WIDTH];
    icdg_pkg::t_pixel r_mem_newer [icdg_pkg::MAX_WIDTH];
    icdg_pkg::t_pixel r_rd_older;
    icdg_pkg::t_pixel r_rd_newer;
    logic             r_wb_valid;

    // Work stage.
    logic             r_s1_valid;
    icdg_pkg::t_stage r_s1, n_s1;
    logic             r_s1_sel;

    // Output register.
    logic             r_out_valid;
    icdg_pkg::t_slope r_out_slope;
    icdg_pkg::t_row   r_out_row;
    icdg_pkg::t_col   r_out_col;
    logic             r_out_last;

    logic [icdg_pkg::WIDTH_BITS-1:0]  width_eff;
    logic [icdg_pkg::HEIGHT_BITS-1:0] height_eff;
    logic             last_col;
    logic             last_row;
    logic             pixel_accept;

    icdg_pkg::t_pixel prev_near;
    icdg_pkg::t_pixel prev_far;
    logic             pos_zero;
    logic             pos_one;
    logic             pos_last;
    logic             has_first;
    logic             has_second;
    logic             final_result;
    logic             out_free;
    logic             out_load;
    logic             s1_done;
    logic signed [icdg_pkg::PIXEL_BITS:0] diff_near;
    logic signed [icdg_pkg::PIXEL_BITS:0] diff_far;
    icdg_pkg::t_slope slope_near;
    icdg_pkg::t_slope slope_far;
    icdg_pkg::t_slope res_slope;
    icdg_pkg::t_row   res_row;
    icdg_pkg::t_col   res_col;
    logic             res_last;

    // Configuration writes are always taken; unknown indexes are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis_mode    <= icdg_pkg::AXIS_X;
            r_image_width  <= icdg_pkg::WIDTH_RESET;
            r_image_height <= icdg_pkg::HEIGHT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                icdg_pkg::CFG_AXIS_MODE:    r_axis_mode    <= i_cfg_data[0];
                icdg_pkg::CFG_IMAGE_WIDTH:  r_image_width  <=
                    i_cfg_data[icdg_pkg::WIDTH_BITS-1:0];
                icdg_pkg::CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp the frame size into the supported range.
    always_comb begin
        if (r_image_width < icdg_pkg::WIDTH_BITS'(2)) begin
            width_eff = icdg_pkg::WIDTH_BITS'(2);
        end else if (r_image_width > icdg_pkg::WIDTH_BITS'(icdg_pkg::MAX_WIDTH)) begin
            width_eff = icdg_pkg::WIDTH_BITS'(icdg_pkg::MAX_WIDTH);
        end else begin
            width_eff = r_image_width;
        end
        if (r_image_height < icdg_pkg::HEIGHT_BITS'(2)) begin
            height_eff = icdg_pkg::HEIGHT_BITS'(2);
        end else if (r_image_height > icdg_pkg::HEIGHT_BITS'(icdg_pkg::MAX_HEIGHT)) begin
            height_eff = icdg_pkg::HEIGHT_BITS'(icdg_pkg::MAX_HEIGHT);
        end else begin
            height_eff = r_image_height;
        end
    end

    // A count at or past the last index closes the line or the frame.
    assign last_col = {1'b0, r_col_count} >= (width_eff - icdg_pkg::WIDTH_BITS'(1));
    assign last_row = {1'b0, r_row_count} >= (height_eff - icdg_pkg::HEIGHT_BITS'(1));

    assign pixel_accept = i_pixel_valid && o_pixel_ready;

    // Next raster position.
    always_comb begin
        n_col_count = r_col_count + icdg_pkg::COL_BITS'(1);
        n_row_count = r_row_count;
        if (last_col) begin
            n_col_count = '0;
            n_row_count = last_row ? '0 : r_row_count + icdg_pkg::ROW_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_count      <= '0;
            r_row_count      <= '0;
            r_pix_before     <= '0;
            r_pix_two_before <= '0;
        end else if (pixel_accept) begin
            r_col_count      <= n_col_count;
            r_row_count      <= n_row_count;
            r_pix_before     <= i_pixel;
            r_pix_two_before <= r_pix_before;
        end
    end

    // Newer buffer: read the old entry and store the new pixel in the same beat.
    always_ff @(posedge i_clk) begin
        if (pixel_accept) begin
            r_rd_newer                <= r_mem_newer[r_col_count];
            r_mem_newer[r_col_count]  <= i_pixel;
        end
    end

    // Older buffer: read on accept, take the displaced newer entry in the next cycle.
    always_ff @(posedge i_clk) begin
        if (pixel_accept) begin
            r_rd_older <= r_mem_older[r_col_count];
        end
        if (r_wb_valid) begin
            r_mem_older[r_s1.col] <= r_rd_newer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_valid <= 1'b0;
        end else begin
            r_wb_valid <= pixel_accept;
        end
    end

    // Work stage load value.
    always_comb begin
        n_s1.pix            = i_pixel;
        n_s1.pix_before     = r_pix_before;
        n_s1.pix_two_before = r_pix_two_before;
        n_s1.mode           = r_axis_mode;
        n_s1.col            = r_col_count;
        n_s1.row            = r_row_count;
        n_s1.last_col       = last_col;
        n_s1.last_row       = last_row;
    end

    // Select neighbors and position along the chosen axis.
    always_comb begin
        if (r_s1.mode == icdg_pkg::AXIS_Y) begin
            prev_near = r_rd_newer;
            prev_far  = r_rd_older;
            pos_zero  = (r_s1.row == '0);
            pos_one   = (r_s1.row == icdg_pkg::ROW_BITS'(1));
            pos_last  = r_s1.last_row;
        end else begin
            prev_near = r_s1.pix_before;
            prev_far  = r_s1.pix_two_before;
            pos_zero  = (r_s1.col == '0);
            pos_one   = (r_s1.col == icdg_pkg::COL_BITS'(1));
            pos_last  = r_s1.last_col;
        end
    end

    // One-sided differences are doubled; central differences are already twice the slope.
    assign diff_near  = {r_s1.pix[icdg_pkg::PIXEL_BITS-1], r_s1.pix}
                      - {prev_near[icdg_pkg::PIXEL_BITS-1], prev_near};
    assign diff_far   = {r_s1.pix[icdg_pkg::PIXEL_BITS-1], r_s1.pix}
                      - {prev_far[icdg_pkg::PIXEL_BITS-1], prev_far};
    assign slope_near = {diff_near, 1'b0};
    assign slope_far  = {diff_far[icdg_pkg::PIXEL_BITS], diff_far};

    assign has_first    = !pos_zero;
    assign has_second   = has_first && pos_last;
    assign final_result = r_s1_sel || !has_second;

    // Result chosen for the next output beat.
    always_comb begin
        res_slope = slope_near;
        res_row   = r_s1.row;
        res_col   = r_s1.col;
        res_last  = 1'b0;
        if (!r_s1_sel) begin
            if (!pos_one) begin
                res_slope = slope_far;
            end
            if (r_s1.mode == icdg_pkg::AXIS_Y) begin
                res_row = r_s1.row - icdg_pkg::ROW_BITS'(1);
            end else begin
                res_col = r_s1.col - icdg_pkg::COL_BITS'(1);
            end
        end else begin
            res_last = (r_s1.mode == icdg_pkg::AXIS_Y) ? r_s1.last_col : r_s1.last_row;
        end
    end

    // Handshake between input, work stage and output register.
    assign out_free      = !r_out_valid || i_result_ready;
    assign out_load      = r_s1_valid && has_first && out_free;
    assign s1_done       = r_s1_valid && (!has_first || (out_free && final_result));
    assign o_pixel_ready = !r_s1_valid || s1_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_sel   <= 1'b0;
        end else begin
            if (pixel_accept) begin
                r_s1_valid <= 1'b1;
                r_s1_sel   <= 1'b0;
            end else if (s1_done) begin
                r_s1_valid <= 1'b0;
                r_s1_sel   <= 1'b0;
            end else if (out_load) begin
                r_s1_sel   <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pixel_accept) begin
            r_s1 <= n_s1;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= out_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_slope <= res_slope;
            r_out_row   <= res_row;
            r_out_col   <= res_col;
            r_out_last  <= res_last;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_slope        = r_out_slope;
    assign o_out_row      = r_out_row;
    assign o_out_column   = r_out_col;
    assign o_frame_last   = r_out_last;

endmodule

### dv/image_central_difference_gradient_tb.sv
// Self-checking testbench of the central-difference image gradient, with a queue-fed driver.
module image_central_difference_gradient_tb;

    // The fourth register index is unused and must be ignored by the block.
    localparam icdg_pkg::t_cfg_index CFG_SPARE = 2'd3;
    // Cycles to let pass after the last expected beat, for pixels that give no result.
    localparam int IDLE_TAIL = 10;
    // Long receiver hold-off, the input count that starts it and the backlog it needs.
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_START   = 100;
    localparam int HOLD_BACKLOG = 8;

    typedef struct packed {
        icdg_pkg::t_slope slope;
        icdg_pkg::t_row   row;
        icdg_pkg::t_col   column;
        logic             last;
    } t_gradient;

    typedef enum logic [1:0] {RX_ALWAYS, RX_MOSTLY, RX_RARELY, RX_PATTERN} t_rx_style;

    // Ports of the block.
    logic                               i_clk          = 1'b0;
    logic                               i_rst_n        = 1'b0;
    logic                               i_pixel_valid  = 1'b0;
    logic                               o_pixel_ready;
    icdg_pkg::t_pixel                   i_pixel        = '0;
    logic                               o_result_valid;
    logic                               i_result_ready = 1'b0;
    icdg_pkg::t_slope                   o_slope;
    icdg_pkg::t_row                     o_out_row;
    icdg_pkg::t_col                     o_out_column;
    logic                               o_frame_last;
    logic                               i_cfg_valid    = 1'b0;
    logic                               o_cfg_ready;
    icdg_pkg::t_cfg_index               i_cfg_index    = icdg_pkg::CFG_AXIS_MODE;
    logic [icdg_pkg::CFG_DATA_BITS-1:0] i_cfg_data     = '0;

    // Predicted registers and state of the block, at their reset values.
    logic                             axis_sel   = icdg_pkg::AXIS_X;
    logic [icdg_pkg::WIDTH_BITS-1:0]  width_sel  = icdg_pkg::WIDTH_RESET;
    logic [icdg_pkg::HEIGHT_BITS-1:0] height_sel = icdg_pkg::HEIGHT_RESET;
    icdg_pkg::t_pixel                 line_older [icdg_pkg::MAX_WIDTH];
    icdg_pkg::t_pixel                 line_newer [icdg_pkg::MAX_WIDTH];
    icdg_pkg::t_pixel                 prev_pixel  = '0;
    icdg_pkg::t_pixel                 prev2_pixel = '0;
    int unsigned                      col_pos = 0;
    int unsigned                      row_pos = 0;

    // Pending pixels and gradients still to come out.
    icdg_pkg::t_pixel pixel_q[$];
    t_gradient        gradient_q[$];

    int          errors       = 0;
    int unsigned pixels_in    = 0;
    int unsigned results_seen = 0;
    int unsigned cfg_writes   = 0;
    int unsigned frames_sent  = 0;

    // Driver and receiver private state.
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;
    int unsigned hold_left  = 0;
    logic        hold_done  = 1'b0;
    int unsigned rx_phase   = 0;
    t_rx_style   rx_style   = RX_ALWAYS;
    logic [15:0] rx_pattern = 16'hFFFF;

    icdg_pkg::t_pixel opening_row [10] = '{
        icdg_pkg::t_pixel'(32767), icdg_pkg::t_pixel'(-32768),
        icdg_pkg::t_pixel'(32767), icdg_pkg::t_pixel'(-32768),
        icdg_pkg::t_pixel'(0), icdg_pkg::t_pixel'(1), icdg_pkg::t_pixel'(-1),
        icdg_pkg::t_pixel'(12345), icdg_pkg::t_pixel'(-12345), icdg_pkg::t_pixel'(100)
    };

    image_central_difference_gradient i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pixel_valid  (i_pixel_valid),
        .o_pixel_ready  (o_pixel_ready),
        .i_pixel        (i_pixel),
        .o_result_valid (o_result_valid),
        .i_result_ready (i_result_ready),
        .o_slope        (o_slope),
        .o_out_row      (o_out_row),
        .o_out_column   (o_out_column),
        .o_frame_last   (o_frame_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // Clock with a period of 20.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Sizes below 2 act as 2, sizes above the maximum act as the maximum.
    function automatic int unsigned clamp_size(input int unsigned v, input int unsigned hi);
        return (v < 2) ? 2 : ((v > hi) ? hi : v);
    endfunction

    function automatic void push_gradient(input int slope, input int unsigned row,
                                          input int unsigned column, input logic last);
        t_gradient g;
        g.slope  = icdg_pkg::t_slope'(slope);
        g.row    = icdg_pkg::t_row'(row);
        g.column = icdg_pkg::t_col'(column);
        g.last   = last;
        gradient_q.push_back(g);
    endfunction

    // Works out the gradients that one accepted pixel releases and advances the raster state.
    task automatic predict_gradient(input icdg_pkg::t_pixel p);
        int unsigned w, h, c, r, ci;
        logic        at_col_end, at_row_end;
        w = clamp_size(32'(width_sel), icdg_pkg::MAX_WIDTH);
        h = clamp_size(32'(height_sel), icdg_pkg::MAX_HEIGHT);
        c = col_pos;
        r = row_pos;
        at_col_end = (c >= w - 1);
        at_row_end = (r >= h - 1);
        ci = (c < icdg_pkg::MAX_WIDTH) ? c : icdg_pkg::MAX_WIDTH - 1;
        if (axis_sel == icdg_pkg::AXIS_X) begin
            // One-sided difference on the first and last columns, central inside the row.
            if (c == 1)
                push_gradient(2 * (int'(p) - int'(prev_pixel)), r, 0, 1'b0);
            else if (c >= 2)
                push_gradient(int'(p) - int'(prev2_pixel), r, c - 1, 1'b0);
            if (at_col_end && c >= 1)
                push_gradient(2 * (int'(p) - int'(prev_pixel)), r, c, at_row_end);
        end else begin
            // The same across rows, with the two line buffers as the earlier rows.
            if (r == 1)
                push_gradient(2 * (int'(p) - int'(line_newer[ci])), 0, c, 1'b0);
            else if (r >= 2)
                push_gradient(int'(p) - int'(line_older[ci]), r - 1, c, 1'b0);
            if (at_row_end && r >= 1)
                push_gradient(2 * (int'(p) - int'(line_newer[ci])), r, c, at_col_end);
        end
        line_older[ci] = line_newer[ci];
        line_newer[ci] = p;
        prev2_pixel = prev_pixel;
        prev_pixel  = p;
        if (at_col_end) begin
            col_pos = 0;
            row_pos = at_row_end ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endtask

    // Writes one register and waits for its beat.
    task automatic write_reg(input icdg_pkg::t_cfg_index idx,
                             input logic [icdg_pkg::CFG_DATA_BITS-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Waits until every pixel is taken and every gradient has come out, then a little longer.
    task automatic wait_idle();
        do @(posedge i_clk);
        while (pixel_q.size() != 0 || i_pixel_valid || gradient_q.size() != 0);
        repeat (IDLE_TAIL) @(posedge i_clk);
    endtask

    // Sets up the block for one frame, queues a frame of pixels and waits for it to drain.
    task automatic send_frame(input logic mode,
                              input logic [icdg_pkg::CFG_DATA_BITS-1:0] wd,
                              input logic [icdg_pkg::CFG_DATA_BITS-1:0] hd);
        int unsigned      n;
        icdg_pkg::t_pixel p;
        write_reg(icdg_pkg::CFG_AXIS_MODE, icdg_pkg::CFG_DATA_BITS'(mode));
        write_reg(icdg_pkg::CFG_IMAGE_WIDTH, wd);
        write_reg(icdg_pkg::CFG_IMAGE_HEIGHT, hd);
        n = clamp_size(32'(wd[icdg_pkg::WIDTH_BITS-1:0]), icdg_pkg::MAX_WIDTH)
          * clamp_size(32'(hd), icdg_pkg::MAX_HEIGHT);
        p = '0;
        for (int unsigned k = 0; k < n; k++) begin
            case ($urandom_range(0, 7))
                0:       p = icdg_pkg::t_pixel'(32767);
                1:       p = icdg_pkg::t_pixel'(-32768);
                2:       p = p + icdg_pkg::t_pixel'(int'($urandom_range(0, 8)) - 4);
                default: p = icdg_pkg::t_pixel'($urandom);
            endcase
            pixel_q.push_back(p);
        end
        frames_sent++;
        wait_idle();
    endtask

    // Pixel driver: bursts of beats with random gaps, fed from the pixel queue.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_pixel_valid <= 1'b0;
        end else if (!i_pixel_valid || o_pixel_ready) begin
            if (gap_left > 0) begin
                gap_left--;
                i_pixel_valid <= 1'b0;
            end else if (pixel_q.size() > 0) begin
                i_pixel_valid <= 1'b1;
                i_pixel       <= pixel_q.pop_front();
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                             : $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                i_pixel_valid <= 1'b0;
            end
        end
    end

    // Result receiver: stalls on its own changing pattern, with one long hold-off that
    // starts while pixels are still waiting to be sent.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_result_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_result_ready <= 1'b0;
        end else if (!hold_done && pixels_in >= HOLD_START
                     && pixel_q.size() > HOLD_BACKLOG) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            i_result_ready <= 1'b0;
        end else begin
            if (rx_phase == 0) begin
                rx_style   = t_rx_style'($urandom_range(0, 3));
                rx_phase   = $urandom_range(20, 120);
                rx_pattern = 16'($urandom);
            end else begin
                rx_phase--;
            end
            case (rx_style)
                RX_ALWAYS:  i_result_ready <= 1'b1;
                RX_MOSTLY:  i_result_ready <= ($urandom_range(0, 3) != 0);
                RX_RARELY:  i_result_ready <= ($urandom_range(0, 3) == 0);
                RX_PATTERN: begin
                    i_result_ready <= rx_pattern[0];
                    rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
                end
                default:    i_result_ready <= 1'b1;
            endcase
        end
    end

    // Monitor: tracks register writes, predicts each accepted pixel, checks each result beat.
    always @(posedge i_clk) begin : result_monitor
        t_gradient want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                cfg_writes++;
                case (i_cfg_index)
                    icdg_pkg::CFG_AXIS_MODE:    axis_sel   = i_cfg_data[0];
                    icdg_pkg::CFG_IMAGE_WIDTH:  width_sel  =
                        i_cfg_data[icdg_pkg::WIDTH_BITS-1:0];
                    icdg_pkg::CFG_IMAGE_HEIGHT: height_sel =
                        i_cfg_data[icdg_pkg::HEIGHT_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_pixel_valid && o_pixel_ready) begin
                predict_gradient(i_pixel);
                pixels_in <= pixels_in + 1;
            end
            if (o_result_valid && i_result_ready) begin
                results_seen++;
                if (gradient_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result beat, slope %0d row %0d column %0d",
                             $time, $signed(o_slope), o_out_row, o_out_column);
                end else begin
                    want = gradient_q.pop_front();
                    if (o_slope !== want.slope) begin
                        errors++;
                        $display("%0t: slope expected %0d, actual %0d", $time,
                                 $signed(want.slope), $signed(o_slope));
                    end
                    if (o_out_row !== want.row) begin
                        errors++;
                        $display("%0t: row expected %0d, actual %0d", $time,
                                 want.row, o_out_row);
                    end
                    if (o_out_column !== want.column) begin
                        errors++;
                        $display("%0t: column expected %0d, actual %0d", $time,
                                 want.column, o_out_column);
                    end
                    if (o_frame_last !== want.last) begin
                        errors++;
                        $display("%0t: frame_last expected %0b, actual %0b", $time,
                                 want.last, o_frame_last);
                    end
                end
            end
        end
    end

    // Stimulus: directed cases first, then random frames.
    initial begin : stimulus
        int unsigned                        random_items;
        logic                               mode;
        logic [icdg_pkg::CFG_DATA_BITS-1:0] wd, hd;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Part of a row at the reset sizes, with full-scale steps between its first pixels.
        foreach (opening_row[k]) pixel_q.push_back(opening_row[k]);
        wait_idle();

        // Shrinking the width mid-row: the current column is already past the new end.
        write_reg(icdg_pkg::CFG_IMAGE_WIDTH, 13'd4);
        pixel_q.push_back(icdg_pkg::t_pixel'(-200));
        wait_idle();

        // Shrinking the height mid-frame makes the current row the last one.
        write_reg(icdg_pkg::CFG_IMAGE_HEIGHT, 13'd2);
        pixel_q.push_back(icdg_pkg::t_pixel'(-32768));
        pixel_q.push_back(icdg_pkg::t_pixel'(32767));
        pixel_q.push_back(icdg_pkg::t_pixel'(0));
        pixel_q.push_back(icdg_pkg::t_pixel'(-32768));
        wait_idle();

        // Sizes of zero clamp to 2; the spare index must change nothing.
        write_reg(icdg_pkg::CFG_AXIS_MODE, icdg_pkg::CFG_DATA_BITS'(icdg_pkg::AXIS_Y));
        write_reg(icdg_pkg::CFG_IMAGE_WIDTH, 13'd0);
        write_reg(icdg_pkg::CFG_IMAGE_HEIGHT, 13'd0);
        write_reg(CFG_SPARE, 13'h1FFF);
        pixel_q.push_back(icdg_pkg::t_pixel'(-32768));
        pixel_q.push_back(icdg_pkg::t_pixel'(32767));
        pixel_q.push_back(icdg_pkg::t_pixel'(32767));
        pixel_q.push_back(icdg_pkg::t_pixel'(-32768));
        frames_sent++;
        wait_idle();
        send_frame(icdg_pkg::AXIS_Y, 13'd3, 13'd3);

        // Sizes of one clamp to 2.
        send_frame(icdg_pkg::AXIS_X, 13'd1, 13'd1);

        // Random frames, mostly small.
        random_items = 0;
        while (random_items < 700) begin
            mode = icdg_pkg::AXIS_X;
            if ($urandom_range(0, 1) == 1) mode = icdg_pkg::AXIS_Y;
            if ($urandom_range(0, 9) == 0) wd = icdg_pkg::CFG_DATA_BITS'($urandom_range(13, 48));
            else wd = icdg_pkg::CFG_DATA_BITS'($urandom_range(2, 12));
            hd = icdg_pkg::CFG_DATA_BITS'($urandom_range(2, 6));
            send_frame(mode, wd, hd);
            random_items += 32'(wd) * 32'(hd);
        end

        $display("Run covered %0d frames in both axes: %0d pixels in, %0d results checked.",
                 frames_sent, pixels_in, results_seen);
        $display("Register writes: %0d, with clamped, minimal and mid-frame sizes.",
                 cfg_writes);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #20000000;
        $display("Timeout with %0d results still expected.", gradient_q.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

### sim.f
rtl/core/icdg_pkg.sv
rtl/core/image_central_difference_gradient.sv
dv/image_central_difference_gradient_tb.sv
